[rtl/hcbd_pkg.sv]
package hcbd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       segment_end;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] body_byte;
    logic [2:0] error_code;
    logic       segment_end_out;
  } out_beat_t;

  typedef enum logic [8:0] {
    ST_LEN      = 9'b000000001,
    ST_EXT      = 9'b000000010,
    ST_HDR_LF   = 9'b000000100,
    ST_DATA     = 9'b000001000,
    ST_DATA_CR  = 9'b000010000,
    ST_DATA_LF  = 9'b000100000,
    ST_TRAILER  = 9'b001000000,
    ST_DONE     = 9'b010000000,
    ST_ERR      = 9'b100000000
  } parse_state_t;

  localparam logic [2:0] KIND_FRAME    = 3'd0;
  localparam logic [2:0] KIND_DATA     = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_ERROR    = 3'd3;
  localparam logic [2:0] KIND_IGNORED  = 3'd4;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_LEN     = 3'd1;
  localparam logic [2:0] ERR_HDR_NO_LF   = 3'd2;
  localparam logic [2:0] ERR_DATA_NO_CR  = 3'd3;
  localparam logic [2:0] ERR_DATA_NO_LF  = 3'd4;
  localparam logic [2:0] ERR_TRAILER     = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd6;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;

endpackage

[rtl/http_chunked_body_decoder_top.sv]
// Chunked transfer body decoder for HTTP/1.1 message bodies.
// The input channel takes one raw body byte per beat, with a flag that marks
// the last byte of a delivered buffer. Every input beat yields exactly one
// result beat: a framing byte, a body data byte, the body-complete marker,
// an error, or an ignored byte once the body has ended.
// Each accepted byte is classified and the parser state updated in the same
// cycle, and the result is held in an output register, so the result beat is
// offered in the cycle after acceptance. One byte per cycle is sustained while
// the receiver takes every result beat; a stall holds the input channel.
// When the receiver stalls, the input channel keeps accepting as long as the
// output register is empty or is being emptied in the same cycle.
// Reset puts the parser at the start of a chunk size line with a zero size
// and empties the output register. Errors are sticky until reset, and every
// byte after the terminating empty trailer line is reported as ignored.
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hcbd_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hcbd_pkg::out_beat_t out_data
);
  import hcbd_pkg::*;

  parse_state_t         state_r, state_nxt;
  logic [SIZE_BITS-1:0] remain_r, remain_nxt;
  logic [2:0]           err_code_r, err_code_nxt;
  logic                 line_empty_r, line_empty_nxt;
  logic                 cr_seen_r, cr_seen_nxt;
  logic                 out_valid_r;
  out_beat_t            out_data_r, result;

  logic       accept;
  logic [7:0] c;
  logic       is_hex;
  logic [3:0] hex_val;
  logic [SIZE_BITS-1:0] remain_dec;

  assign c        = in_data.in_byte;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign remain_dec = remain_r - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      hex_val = 4'(c - CHAR_0);
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      hex_val = 4'(c - CHAR_LC_A + 8'd10);
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      hex_val = 4'(c - CHAR_UC_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    logic [2:0] kind;
    logic [2:0] fail_code;
    kind           = KIND_FRAME;
    fail_code      = ERR_NONE;
    state_nxt      = state_r;
    remain_nxt     = remain_r;
    err_code_nxt   = err_code_r;
    line_empty_nxt = line_empty_r;
    cr_seen_nxt    = cr_seen_r;
    case (state_r)
      ST_LEN: begin
        if (is_hex) begin
          if (remain_r[SIZE_BITS-1 -: 4] != 4'd0) begin
            fail_code = ERR_OVERFLOW;
          end else begin
            remain_nxt = {remain_r[SIZE_BITS-5:0], hex_val};
          end
        end else if (c == CHAR_SEMI) begin
          state_nxt = ST_EXT;
        end else if (c == CHAR_CR) begin
          state_nxt = ST_HDR_LF;
        end else begin
          fail_code = ERR_BAD_LEN;
        end
      end
      ST_EXT: begin
        if (c == CHAR_CR) begin
          state_nxt = ST_HDR_LF;
        end
      end
      ST_HDR_LF: begin
        if (c != CHAR_LF) begin
          fail_code = ERR_HDR_NO_LF;
        end else if (remain_r == '0) begin
          state_nxt      = ST_TRAILER;
          line_empty_nxt = 1'b1;
          cr_seen_nxt    = 1'b0;
        end else begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        kind = KIND_DATA;
        if (remain_r != '0) begin
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            state_nxt = ST_DATA_CR;
          end
        end else begin
          state_nxt = ST_DATA_CR;
        end
      end
      ST_DATA_CR: begin
        if (c == CHAR_CR) begin
          state_nxt = ST_DATA_LF;
        end else begin
          fail_code = ERR_DATA_NO_CR;
        end
      end
      ST_DATA_LF: begin
        if (c == CHAR_LF) begin
          state_nxt = ST_LEN;
        end else begin
          fail_code = ERR_DATA_NO_LF;
        end
      end
      ST_TRAILER: begin
        if (c == CHAR_CR) begin
          if (cr_seen_r) begin
            fail_code = ERR_TRAILER;
          end else begin
            cr_seen_nxt = 1'b1;
          end
        end else if (c == CHAR_LF) begin
          if (!cr_seen_r) begin
            fail_code = ERR_TRAILER;
          end else if (line_empty_r) begin
            kind      = KIND_COMPLETE;
            state_nxt = ST_DONE;
          end else begin
            line_empty_nxt = 1'b1;
            cr_seen_nxt    = 1'b0;
          end
        end else begin
          if (cr_seen_r) begin
            fail_code = ERR_TRAILER;
          end else begin
            line_empty_nxt = 1'b0;
          end
        end
      end
      ST_ERR: begin
        kind = KIND_ERROR;
      end
      default: begin
        kind = KIND_IGNORED;
      end
    endcase
    if (fail_code != ERR_NONE) begin
      kind         = KIND_ERROR;
      state_nxt    = ST_ERR;
      err_code_nxt = fail_code;
    end
    result.kind            = kind;
    result.body_byte       = (kind == KIND_DATA) ? c : 8'd0;
    result.error_code      = (kind == KIND_ERROR) ? err_code_nxt : ERR_NONE;
    result.segment_end_out = in_data.segment_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LEN;
      remain_r     <= '0;
      err_code_r   <= ERR_NONE;
      line_empty_r <= 1'b1;
      cr_seen_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        state_r      <= state_nxt;
        remain_r     <= remain_nxt;
        err_code_r   <= err_code_nxt;
        line_empty_r <= line_empty_nxt;
        cr_seen_r    <= cr_seen_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[bench/tb_http_chunked_body_decoder_top.sv]
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder_top;
  import hcbd_pkg::*;

  localparam int SIZE_BITS = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BYTES = 1400;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    in_beat_t beat;
    bit       hold_for_drain;
  } feed_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  feed_item_t feed_q[$];
  out_beat_t  expected_q[$];
  int         feed_total = 0;
  int         accepted_total = 0;
  int         waiting_results = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  int         sent_count = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         drain_next = 1'b0;

  parse_state_t         mode;
  logic [2:0]           sticky_code;
  logic [SIZE_BITS-1:0] chunk_left;
  logic                 line_empty;
  logic                 line_cr;

  http_chunked_body_decoder_top #(
    .SIZE_BITS(SIZE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial forever #5 clk = ~clk;

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] d;
    v = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = c - CHAR_0;
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      d = c - CHAR_LC_A + 8'd10;
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      d = c - CHAR_UC_A + 8'd10;
    end else begin
      return 1'b0;
    end
    v = d[3:0];
    return 1'b1;
  endfunction

  function automatic out_beat_t decode_byte(input in_beat_t b);
    out_beat_t  r;
    logic [2:0] fault;
    logic [3:0] nib;
    bit         is_hex;
    r = '0;
    r.kind = KIND_FRAME;
    r.segment_end_out = b.segment_end;
    fault = ERR_NONE;
    is_hex = hex_nibble(b.in_byte, nib);
    case (mode)
      ST_LEN: begin
        if (is_hex) begin
          if (chunk_left[SIZE_BITS-1 -: 4] != 4'd0) fault = ERR_OVERFLOW;
          else chunk_left = {chunk_left[SIZE_BITS-5:0], nib};
        end else if (b.in_byte == CHAR_SEMI) begin
          mode = ST_EXT;
        end else if (b.in_byte == CHAR_CR) begin
          mode = ST_HDR_LF;
        end else begin
          fault = ERR_BAD_LEN;
        end
      end
      ST_EXT: begin
        if (b.in_byte == CHAR_CR) mode = ST_HDR_LF;
      end
      ST_HDR_LF: begin
        if (b.in_byte != CHAR_LF) begin
          fault = ERR_HDR_NO_LF;
        end else if (chunk_left == '0) begin
          mode = ST_TRAILER;
          line_empty = 1'b1;
          line_cr = 1'b0;
        end else begin
          mode = ST_DATA;
        end
      end
      ST_DATA: begin
        r.kind = KIND_DATA;
        r.body_byte = b.in_byte;
        if (chunk_left != '0) chunk_left = chunk_left - SIZE_BITS'(1);
        if (chunk_left == '0) mode = ST_DATA_CR;
      end
      ST_DATA_CR: begin
        if (b.in_byte == CHAR_CR) mode = ST_DATA_LF;
        else fault = ERR_DATA_NO_CR;
      end
      ST_DATA_LF: begin
        if (b.in_byte == CHAR_LF) mode = ST_LEN;
        else fault = ERR_DATA_NO_LF;
      end
      ST_TRAILER: begin
        if (b.in_byte == CHAR_CR) begin
          if (line_cr) fault = ERR_TRAILER;
          else line_cr = 1'b1;
        end else if (b.in_byte == CHAR_LF) begin
          if (!line_cr) begin
            fault = ERR_TRAILER;
          end else if (line_empty) begin
            r.kind = KIND_COMPLETE;
            mode = ST_DONE;
          end else begin
            line_empty = 1'b1;
            line_cr = 1'b0;
          end
        end else if (line_cr) begin
          fault = ERR_TRAILER;
        end else begin
          line_empty = 1'b0;
        end
      end
      ST_ERR: r.kind = KIND_ERROR;
      default: r.kind = KIND_IGNORED;
    endcase
    if (fault != ERR_NONE) begin
      mode = ST_ERR;
      sticky_code = fault;
      r.kind = KIND_ERROR;
    end
    if (r.kind == KIND_ERROR) r.error_code = sticky_code;
    return r;
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_other(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == a || c == b) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CHAR_0 + {4'd0, v};
    if ($urandom_range(0, 1) == 1) return CHAR_UC_A + {4'd0, v - 4'd10};
    return CHAR_LC_A + {4'd0, v - 4'd10};
  endfunction

  task automatic put_byte(input logic [7:0] c);
    feed_item_t entry;
    entry.beat.in_byte = c;
    entry.beat.segment_end = ($urandom_range(0, 3) == 0);
    entry.hold_for_drain = drain_next;
    drain_next = 1'b0;
    feed_q.push_back(entry);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_crlf();
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
  endtask

  task automatic put_data(input int unsigned n);
    repeat (n) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_field_text();
    repeat ($urandom_range(1, 20)) put_byte(pick_other(CHAR_CR, CHAR_LF));
  endtask

  // Size digits in mixed case, optional leading zeros and extension, then CR.
  task automatic put_size_line(input int unsigned n);
    logic [3:0]  digits[$];
    int unsigned rest;
    int          zeros;
    rest = n;
    while (rest != 0) begin
      digits.push_front(rest[3:0]);
      rest = rest >> 4;
    end
    if (n == 0) zeros = $urandom_range(0, 3);
    else zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) put_byte(CHAR_0);
    foreach (digits[i]) put_byte(hex_char(digits[i]));
    if ($urandom_range(0, 3) == 0) begin
      put_byte(CHAR_SEMI);
      repeat ($urandom_range(0, 6)) put_byte(pick_other(CHAR_CR, CHAR_CR));
    end
    put_byte(CHAR_CR);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (feed_q.size() != 0 &&
                   (!feed_q[0].hold_for_drain || (!in_valid && waiting_results == 0))) begin
        in_valid <= 1'b1;
        in_data <= feed_q[0].beat;
        void'(feed_q.pop_front());
        sent_count <= sent_count + 1;
        gap_left <= ((sent_count / 128) % 4 == 3) ? 0 : pause_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ((cycle_count / 512) % 4 == 1 || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= pause_len();
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      mode = ST_LEN;
      sticky_code = ERR_NONE;
      chunk_left = '0;
      line_empty = 1'b1;
      line_cr = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no byte pending: kind %0d", out_data.kind);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", int'(want.kind), int'(out_data.kind));
          check_field("body_byte", int'(want.body_byte), int'(out_data.body_byte));
          check_field("error_code", int'(want.error_code), int'(out_data.error_code));
          check_field("segment_end_out", int'(want.segment_end_out),
                      int'(out_data.segment_end_out));
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(decode_byte(in_data));
        accepted_total <= accepted_total + 1;
      end
      waiting_results <= expected_q.size();
    end
  end

  initial begin
    int unsigned n;
    int          drain_mark;
    logic [7:0]  c;
    logic [3:0]  nib;

    put_text("1;");
    put_crlf();
    put_byte(8'hFF);
    put_crlf();
    put_text("02;;");
    put_crlf();
    put_byte(8'h00);
    put_byte(CHAR_CR);
    put_crlf();
    put_text("1");
    put_crlf();
    put_byte(CHAR_LF);
    put_crlf();

    drain_mark = 500;
    while (feed_q.size() < RANDOM_BYTES) begin
      if (feed_q.size() >= drain_mark) begin
        drain_next = 1'b1;
        drain_mark += 500;
      end
      case ($urandom_range(0, 19))
        0: n = $urandom_range(65, 300);
        1, 2, 3, 4, 5: n = $urandom_range(17, 64);
        default: n = $urandom_range(1, 16);
      endcase
      put_size_line(n);
      put_byte(CHAR_LF);
      put_data(n);
      put_crlf();
    end

    // The body ends once per run: either a clean trailer or one sticky error.
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        put_size_line(0);
        put_byte(CHAR_LF);
        repeat ($urandom_range(0, 3)) begin
          put_field_text();
          put_crlf();
        end
        put_crlf();
      end
      4: begin
        if ($urandom_range(0, 1) == 1) put_byte(hex_char(4'($urandom_range(0, 15))));
        c = 8'($urandom_range(0, 255));
        while (hex_nibble(c, nib) || c == CHAR_SEMI || c == CHAR_CR)
          c = 8'($urandom_range(0, 255));
        put_byte(c);
      end
      5: begin
        put_size_line($urandom_range(1, 16));
        put_byte(pick_other(CHAR_LF, CHAR_LF));
      end
      6: begin
        n = $urandom_range(1, 16);
        put_size_line(n);
        put_byte(CHAR_LF);
        put_data(n);
        put_byte(pick_other(CHAR_CR, CHAR_CR));
      end
      7: begin
        n = $urandom_range(1, 16);
        put_size_line(n);
        put_byte(CHAR_LF);
        put_data(n);
        put_byte(CHAR_CR);
        put_byte(pick_other(CHAR_LF, CHAR_LF));
      end
      8: begin
        put_size_line(0);
        put_byte(CHAR_LF);
        repeat ($urandom_range(0, 2)) begin
          put_field_text();
          put_crlf();
        end
        if ($urandom_range(0, 1) == 1) put_field_text();
        case ($urandom_range(0, 2))
          0: begin
            put_byte(CHAR_CR);
            put_byte(CHAR_CR);
          end
          1: begin
            put_byte(CHAR_CR);
            put_byte(pick_other(CHAR_CR, CHAR_LF));
          end
          default: put_byte(CHAR_LF);
        endcase
      end
      default: begin
        put_byte(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 11)) put_byte(hex_char(4'($urandom_range(0, 15))));
      end
    endcase
    put_data($urandom_range(10, 30));
    feed_total = feed_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_total != feed_total || waiting_results != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
